/* design/mfp_pkg.sv */
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types, constants and the CRC step of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mfp_pkg;

	localparam logic [7:0]  START_V2      = 8'hFD;
	localparam logic [7:0]  START_V1      = 8'hFE;
	localparam logic [3:0]  HDR_LEN_V2    = 4'd9;
	localparam logic [3:0]  HDR_LEN_V1    = 4'd5;
	localparam logic [3:0]  SIG_LEN       = 4'd13;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;

	localparam logic [23:0] FIRST_ID_RST  = 24'd0;
	localparam logic [7:0]  FIRST_EX_RST  = 8'd50;
	localparam logic [23:0] SECOND_ID_RST = 24'd253;
	localparam logic [7:0]  SECOND_EX_RST = 8'd83;

	localparam int unsigned ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_FIRST_ID  = 2'd0,
		REG_FIRST_EX  = 2'd1,
		REG_SECOND_ID = 2'd2,
		REG_SECOND_EX = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CRC1    = 3'd3,
		PH_CRC2    = 3'd4,
		PH_SIG     = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_UNKNOWN_ID = 2'd1,
		ST_CRC_BAD    = 2'd2
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD   = 1'b0,
		KIND_FRAME_END = 1'b1
	} kind_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
	endfunction

endpackage

`default_nettype wire

/* design/mavlink_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// mavlink_frame_parser_unit
// Byte-wise MAVLink v1/v2 frame parser with X.25 CRC check.
//
// Bytes enter on rx_valid/rx_byte and are taken when rx_stall is low. Each
// payload byte leaves as a kind 0 item, and each frame leaves one kind 1 item
// with its status; the consumer drops the payload unless that status is 0.
// Bytes outside a frame and header, CRC and signature bytes give no payload item.
// A byte's item reaches res_valid through the input register, then the result
// register; a stall can hold the byte in the input register.
// One byte is taken every cycle while rx_stall is low; the CRC step and the
// parser update sit in one stage between the two registers.
// When res_stall is high the result holds; the input register still
// advances while the result register is empty, so rx_stall rises only when
// both are full. Reset empties both registers, returns the parser to the
// hunt for a start byte and loads the register defaults. The user must write
// the APB port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module mavlink_frame_parser_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rx_valid,
	output logic                             rx_stall,
	input  wire logic [7:0]                  rx_byte,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic                             kind,
	output logic [7:0]                       payload_index,
	output logic [7:0]                       payload_byte,
	output logic [1:0]                       status,
	output logic [23:0]                      message_id,
	output logic [7:0]                       sender_system,
	output logic [7:0]                       sender_component,
	output logic [7:0]                       payload_length,
	output logic                             is_version_two,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mfp_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic [23:0] first_id_q;
	logic [7:0]  first_ex_q;
	logic [23:0] second_id_q;
	logic [7:0]  second_ex_q;
	logic        cfg_wr;
	mfp_pkg::reg_idx_t cfg_idx;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        fire;

	mfp_pkg::phase_t phase_q, phase_d;
	logic        v2_q, v2_d;
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  len_q, len_d;
	logic        signed_q, signed_d;
	logic [7:0]  sys_q, sys_d;
	logic [7:0]  comp_q, comp_d;
	logic [23:0] id_q, id_d;
	logic [7:0]  pay_cnt_q, pay_cnt_d;
	logic [3:0]  sig_cnt_q, sig_cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] rcrc_q, rcrc_d;

	logic [15:0] crc_byte;
	logic [15:0] crc_extra;
	logic [7:0]  extra;
	logic        id_known;
	logic [3:0]  hdr_next;
	logic [3:0]  hdr_len;
	logic [8:0]  pay_next;
	logic [3:0]  sig_next;
	logic [15:0] rcrc_end;

	logic        has_res;
	logic        end_res;
	mfp_pkg::kind_t   res_kind;
	mfp_pkg::status_t res_status;

	logic        res_valid_q;
	logic        kind_q;
	logic [7:0]  idx_q;
	logic [7:0]  pbyte_q;
	logic [1:0]  status_q;
	logic [23:0] mid_q;
	logic [7:0]  osys_q;
	logic [7:0]  ocomp_q;
	logic [7:0]  olen_q;
	logic        ov2_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = mfp_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_id_q  <= mfp_pkg::FIRST_ID_RST;
			first_ex_q  <= mfp_pkg::FIRST_EX_RST;
			second_id_q <= mfp_pkg::SECOND_ID_RST;
			second_ex_q <= mfp_pkg::SECOND_EX_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mfp_pkg::REG_FIRST_ID:  first_id_q  <= pwdata[23:0];
				mfp_pkg::REG_FIRST_EX:  first_ex_q  <= pwdata[7:0];
				mfp_pkg::REG_SECOND_ID: second_id_q <= pwdata[23:0];
				mfp_pkg::REG_SECOND_EX: second_ex_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			mfp_pkg::REG_FIRST_ID:  prdata = {8'h00, first_id_q};
			mfp_pkg::REG_FIRST_EX:  prdata = {24'h000000, first_ex_q};
			mfp_pkg::REG_SECOND_ID: prdata = {8'h00, second_id_q};
			mfp_pkg::REG_SECOND_EX: prdata = {24'h000000, second_ex_q};
			default:                prdata = 32'h0;
		endcase
	end

	// input register
	assign adv      = !res_valid_q || !res_stall;
	assign fire     = valid_s1 && adv;
	assign rx_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser datapath
	assign crc_byte  = mfp_pkg::crc_step(crc_q, byte_s1);
	assign hdr_next  = hdr_cnt_q + 4'd1;
	assign hdr_len   = v2_q ? mfp_pkg::HDR_LEN_V2 : mfp_pkg::HDR_LEN_V1;
	assign pay_next  = {1'b0, pay_cnt_q} + 9'd1;
	assign sig_next  = sig_cnt_q + 4'd1;
	assign rcrc_end  = (phase_q == mfp_pkg::PH_CRC2) ? {byte_s1, rcrc_q[7:0]} : rcrc_q;

	always_comb begin
		id_known = 1'b1;
		extra    = first_ex_q;
		if (id_q == first_id_q) begin
			extra = first_ex_q;
		end else if (id_q == second_id_q) begin
			extra = second_ex_q;
		end else begin
			id_known = 1'b0;
		end
	end

	assign crc_extra = mfp_pkg::crc_step(crc_q, extra);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			mfp_pkg::PH_WAIT: begin
				if (byte_s1 == mfp_pkg::START_V2 || byte_s1 == mfp_pkg::START_V1) begin
					phase_d = mfp_pkg::PH_HEADER;
				end
			end
			mfp_pkg::PH_HEADER: begin
				if (hdr_next >= hdr_len) begin
					phase_d = (len_q != 8'd0) ? mfp_pkg::PH_PAYLOAD : mfp_pkg::PH_CRC1;
				end
			end
			mfp_pkg::PH_PAYLOAD: begin
				if (pay_next >= {1'b0, len_q}) begin
					phase_d = mfp_pkg::PH_CRC1;
				end
			end
			mfp_pkg::PH_CRC1: phase_d = mfp_pkg::PH_CRC2;
			mfp_pkg::PH_CRC2: phase_d = (v2_q && signed_q) ? mfp_pkg::PH_SIG : mfp_pkg::PH_WAIT;
			mfp_pkg::PH_SIG: begin
				if (sig_next >= mfp_pkg::SIG_LEN) begin
					phase_d = mfp_pkg::PH_WAIT;
				end
			end
			default: phase_d = mfp_pkg::PH_WAIT;
		endcase
	end

	// field updates and result
	always_comb begin
		v2_d      = v2_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		signed_d  = signed_q;
		sys_d     = sys_q;
		comp_d    = comp_q;
		id_d      = id_q;
		pay_cnt_d = pay_cnt_q;
		sig_cnt_d = sig_cnt_q;
		crc_d     = crc_q;
		rcrc_d    = rcrc_q;
		has_res   = 1'b0;
		end_res   = 1'b0;
		case (phase_q)
			mfp_pkg::PH_WAIT: begin
				if (byte_s1 == mfp_pkg::START_V2 || byte_s1 == mfp_pkg::START_V1) begin
					v2_d      = (byte_s1 == mfp_pkg::START_V2);
					hdr_cnt_d = 4'd0;
					signed_d  = 1'b0;
					id_d      = 24'd0;
					pay_cnt_d = 8'd0;
					sig_cnt_d = 4'd0;
					crc_d     = mfp_pkg::CRC_INIT;
				end
			end
			mfp_pkg::PH_HEADER: begin
				crc_d     = crc_byte;
				hdr_cnt_d = hdr_next;
				if (v2_q) begin
					case (hdr_cnt_q)
						4'd0: len_d    = byte_s1;
						4'd1: signed_d = byte_s1[0];
						4'd4: sys_d    = byte_s1;
						4'd5: comp_d   = byte_s1;
						4'd6: id_d     = {16'h0000, byte_s1};
						4'd7: id_d     = {id_q[23:16], byte_s1, id_q[7:0]};
						4'd8: id_d     = {byte_s1, id_q[15:0]};
						default: ;
					endcase
				end else begin
					case (hdr_cnt_q)
						4'd0: len_d  = byte_s1;
						4'd2: sys_d  = byte_s1;
						4'd3: comp_d = byte_s1;
						4'd4: id_d   = {16'h0000, byte_s1};
						default: ;
					endcase
				end
				if (hdr_next >= hdr_len) begin
					pay_cnt_d = 8'd0;
				end
			end
			mfp_pkg::PH_PAYLOAD: begin
				crc_d     = crc_byte;
				pay_cnt_d = pay_next[7:0];
				has_res   = 1'b1;
			end
			mfp_pkg::PH_CRC1: begin
				rcrc_d = {8'h00, byte_s1};
			end
			mfp_pkg::PH_CRC2: begin
				rcrc_d = rcrc_end;
				if (v2_q && signed_q) begin
					sig_cnt_d = 4'd0;
				end else begin
					has_res = 1'b1;
					end_res = 1'b1;
				end
			end
			mfp_pkg::PH_SIG: begin
				sig_cnt_d = sig_next;
				if (sig_next >= mfp_pkg::SIG_LEN) begin
					has_res = 1'b1;
					end_res = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res_kind   = end_res ? mfp_pkg::KIND_FRAME_END : mfp_pkg::KIND_PAYLOAD;
		res_status = mfp_pkg::ST_ACCEPTED;
		if (end_res) begin
			if (!id_known) begin
				res_status = mfp_pkg::ST_UNKNOWN_ID;
			end else if (crc_extra != rcrc_end) begin
				res_status = mfp_pkg::ST_CRC_BAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mfp_pkg::PH_WAIT;
			v2_q      <= 1'b0;
			hdr_cnt_q <= 4'd0;
			len_q     <= 8'd0;
			signed_q  <= 1'b0;
			sys_q     <= 8'd0;
			comp_q    <= 8'd0;
			id_q      <= 24'd0;
			pay_cnt_q <= 8'd0;
			sig_cnt_q <= 4'd0;
			crc_q     <= mfp_pkg::CRC_INIT;
			rcrc_q    <= 16'd0;
		end else if (fire) begin
			phase_q   <= phase_d;
			v2_q      <= v2_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			signed_q  <= signed_d;
			sys_q     <= sys_d;
			comp_q    <= comp_d;
			id_q      <= id_d;
			pay_cnt_q <= pay_cnt_d;
			sig_cnt_q <= sig_cnt_d;
			crc_q     <= crc_d;
			rcrc_q    <= rcrc_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= fire && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			kind_q   <= res_kind;
			idx_q    <= end_res ? 8'd0 : pay_cnt_q;
			pbyte_q  <= end_res ? 8'd0 : byte_s1;
			status_q <= res_status;
			mid_q    <= id_q;
			osys_q   <= sys_q;
			ocomp_q  <= comp_q;
			olen_q   <= len_q;
			ov2_q    <= v2_q;
		end
	end

	assign res_valid        = res_valid_q;
	assign kind             = kind_q;
	assign payload_index    = idx_q;
	assign payload_byte     = pbyte_q;
	assign status           = status_q;
	assign message_id       = mid_q;
	assign sender_system    = osys_q;
	assign sender_component = ocomp_q;
	assign payload_length   = olen_q;
	assign is_version_two   = ov2_q;

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == mfp_pkg::KIND_FRAME_END |-> payload_index == 8'd0 && payload_byte == 8'd0)
		else $error("frame end item carries payload data");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == mfp_pkg::KIND_PAYLOAD |-> status == mfp_pkg::ST_ACCEPTED)
		else $error("payload item carries nonzero status");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("input stalled while pipeline can advance");

	a_no_result_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == mfp_pkg::PH_WAIT |=> !res_valid || $stable(res_valid))
		else $error("result raised from idle phase");

endmodule

`default_nettype wire
